// File: rtl/core/tvp_pkg.sv
package tvp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TW        = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_W     = TW + FRAC_BITS;
    localparam int SQ_W      = 2 * TW;
    localparam int PROD_W    = 2 * TW;
    localparam int VW        = PROD_W - FRAC_BITS;
    localparam int CNT_W     = $clog2(NUM_W);

    localparam logic [CFG_W-1:0] ONE_Q = CFG_W'(1) << FRAC_BITS;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_GOAL   = 1'b1;

    localparam logic [1:0] MODE_DISTANCE = 2'd0;
    localparam logic [1:0] MODE_VELOCITY = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TIME     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT_MODE = CFG_IDX_W'(2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_G_ACC,
        S_G_DECIDE,
        S_G_TDIV,
        S_G_SQLD,
        S_G_SQRT,
        S_G_PEAK,
        S_G_TFIN,
        S_G_CDIV,
        S_G_CFIN,
        S_G_RES,
        S_U_SEL,
        S_U_MUL,
        S_U_VEL,
        S_U_DMUL,
        S_U_ACC
    } t_state;

    typedef enum logic [1:0] {
        RG_RAMP,
        RG_CRUISE,
        RG_DOWN,
        RG_STOP
    } t_region;

    typedef struct packed {
        logic                 operation;
        logic [TW-1:0]        time_now;
        logic signed [TW-1:0] goal_position;
        logic signed [TW-1:0] measured_position;
    } t_req;

    typedef struct packed {
        logic signed [TW-1:0] setpoint;
    } t_rsp;

endpackage

// File: rtl/core/tvp_if.sv
interface tvp_req_if;
    logic          valid;
    logic          ready;
    tvp_pkg::t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface tvp_rsp_if;
    logic          valid;
    logic          ready;
    tvp_pkg::t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/trapezoid_velocity_profile.sv
// update request: runs through the select, multiply, velocity, delta multiply and accumulate states
// set-goal request (Q16.16): a triangle profile uses the shared one-bit-per-cycle
// restoring divider, then the one-bit-per-cycle square root unit
// (a cruise profile at Q16.16 uses the divider but not the square root unit)
// not ready while a request is in progress or its result is still waiting
// synchronous active-low reset clears profile state and setpoint and loads config defaults
module trapezoid_velocity_profile (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_cfg_we,
    input  logic [tvp_pkg::CFG_IDX_W-1:0]                     i_cfg_idx,
    input  logic [tvp_pkg::CFG_W-1:0]                         i_cfg_data,
    tvp_req_if.sink                                           i_req,
    tvp_rsp_if.source                                         o_rsp
);

    localparam int F      = tvp_pkg::FRAC_BITS;
    localparam int TW     = tvp_pkg::TW;
    localparam int CW     = tvp_pkg::CFG_W;
    localparam int NUM_W  = tvp_pkg::NUM_W;
    localparam int SQ_W   = tvp_pkg::SQ_W;
    localparam int PROD_W = tvp_pkg::PROD_W;
    localparam int VW     = tvp_pkg::VW;
    localparam int CNT_W  = tvp_pkg::CNT_W;

    tvp_pkg::t_state  r_state, n_state;
    tvp_pkg::t_region r_region;

    logic [CW-1:0]        r_max_vel;
    logic [CW-1:0]        r_ramp;
    logic [1:0]           r_mode;

    logic signed [TW-1:0] r_setpoint;
    logic [TW-1:0]        r_prev_time;
    logic                 r_move_neg;
    logic [TW-1:0]        r_accel;
    logic [TW-1:0]        r_ramp_end;
    logic [TW-1:0]        r_cruise_end;
    logic [TW-1:0]        r_profile_end;
    logic [TW-1:0]        r_peak;

    logic [TW-1:0]        r_time;
    logic signed [TW-1:0] r_meas;
    logic [TW-1:0]        r_mag;
    logic [TW-1:0]        r_mul_a;
    logic [TW-1:0]        r_mul_b;
    logic [PROD_W-1:0]    r_prod;
    logic [NUM_W-1:0]     r_num;
    logic [TW-1:0]        r_rem;
    logic [TW-1:0]        r_den;
    logic [SQ_W-1:0]      r_sq_x;
    logic [TW+1:0]        r_sq_rem;
    logic [TW-1:0]        r_sq_res;
    logic [CNT_W-1:0]     r_cnt;
    logic [CW-1:0]        r_vm;
    logic                 r_dneg;
    logic signed [TW-1:0] r_result;
    logic                 r_out_valid;
    logic signed [TW-1:0] r_out_data;

    logic                 w_accept;
    logic                 w_load_out;
    logic                 w_busy_done;

    // divider step
    logic [TW:0]          w_div_sh;
    logic                 w_div_ge;
    logic [TW-1:0]        w_div_rem;
    logic [NUM_W-1:0]     w_div_num;

    // square root step
    logic [TW+3:0]        w_sq_sh;
    logic [TW+3:0]        w_sq_trial;
    logic                 w_sq_ge;
    logic [TW+1:0]        w_sq_rem;
    logic [TW-1:0]        w_sq_res;

    logic signed [TW:0]   w_dist;
    logic [TW-1:0]        w_quo_sat;
    logic [127:0]         w_xw;
    logic [SQ_W-1:0]      w_x_sat;
    logic [VW-1:0]        w_prod_hi;
    logic                 w_tri;
    logic [TW-1:0]        w_ce;
    logic [TW:0]          w_ce_sum;
    logic [TW:0]          w_tr2;
    logic [VW-1:0]        w_vel;
    logic [CW-1:0]        w_vm;
    logic                 w_tneg;
    logic [TW-1:0]        w_adt;
    logic signed [VW+1:0] w_sp_ext;
    logic signed [VW+1:0] w_delta;
    logic signed [VW+1:0] w_sum;
    logic signed [TW-1:0] w_sum_sat;
    logic signed [TW-1:0] w_vel_signed;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_busy_done = (r_state == tvp_pkg::S_G_RES) || (r_state == tvp_pkg::S_U_ACC);

    assign w_div_sh  = {r_rem, r_num[NUM_W-1]};
    assign w_div_ge  = w_div_sh >= {1'b0, r_den};
    assign w_div_rem = w_div_ge ? TW'(w_div_sh - {1'b0, r_den}) : w_div_sh[TW-1:0];
    assign w_div_num = {r_num[NUM_W-2:0], w_div_ge};

    assign w_sq_sh    = {r_sq_rem, r_sq_x[SQ_W-1 -: 2]};
    assign w_sq_trial = {2'b00, r_sq_res, 2'b01};
    assign w_sq_ge    = w_sq_sh >= w_sq_trial;
    assign w_sq_rem   = w_sq_ge ? (TW+2)'(w_sq_sh - w_sq_trial) : w_sq_sh[TW+1:0];
    assign w_sq_res   = {r_sq_res[TW-2:0], w_sq_ge};

    assign w_dist    = (TW+1)'(i_req.data.goal_position) - (TW+1)'(i_req.data.measured_position);
    assign w_quo_sat = (|r_num[NUM_W-1:TW]) ? '1 : r_num[TW-1:0];
    assign w_xw      = 128'(r_num) << F;
    assign w_x_sat   = (|w_xw[127:SQ_W]) ? '1 : w_xw[SQ_W-1:0];
    assign w_prod_hi = r_prod[PROD_W-1:F];
    assign w_tri     = w_prod_hi > VW'(r_mag);
    assign w_ce      = (w_quo_sat < TW'(r_ramp)) ? TW'(r_ramp) : w_quo_sat;
    assign w_ce_sum  = (TW+1)'(w_ce) + (TW+1)'(r_ramp);
    assign w_tr2     = {r_ramp_end, 1'b0};

    always_comb begin
        case (r_region)
            tvp_pkg::RG_RAMP:   w_vel = w_prod_hi;
            tvp_pkg::RG_CRUISE: w_vel = VW'(r_peak);
            tvp_pkg::RG_DOWN:   w_vel = (VW'(r_peak) > w_prod_hi) ? VW'(r_peak) - w_prod_hi : '0;
            default:            w_vel = '0;
        endcase
    end

    assign w_vm    = (w_vel > VW'({CW{1'b1}})) ? {CW{1'b1}} : w_vel[CW-1:0];
    assign w_tneg  = r_time < r_prev_time;
    assign w_adt   = w_tneg ? r_prev_time - r_time : r_time - r_prev_time;

    assign w_sp_ext     = (VW+2)'(r_setpoint);
    assign w_delta      = r_dneg ? -$signed({2'b00, w_prod_hi}) : $signed({2'b00, w_prod_hi});
    assign w_sum        = w_sp_ext + w_delta;
    assign w_sum_sat    = (w_sum[VW+1:TW-1] == '0 || w_sum[VW+1:TW-1] == '1)
                          ? w_sum[TW-1:0]
                          : (w_sum[VW+1] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}});
    assign w_vel_signed = r_move_neg ? TW'(0) - TW'(r_vm) : TW'(r_vm);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tvp_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.data.operation == tvp_pkg::OP_GOAL)
                              ? tvp_pkg::S_G_ACC : tvp_pkg::S_U_SEL;
                end
            end
            tvp_pkg::S_G_ACC: begin
                if (r_den == '0 || r_cnt == '0) begin
                    n_state = tvp_pkg::S_G_DECIDE;
                end
            end
            tvp_pkg::S_G_DECIDE: begin
                if (w_tri) begin
                    n_state = (r_accel == '0) ? tvp_pkg::S_G_SQLD : tvp_pkg::S_G_TDIV;
                end else begin
                    n_state = (r_max_vel == '0) ? tvp_pkg::S_G_CFIN : tvp_pkg::S_G_CDIV;
                end
            end
            tvp_pkg::S_G_TDIV: begin
                if (r_cnt == '0) begin
                    n_state = tvp_pkg::S_G_SQLD;
                end
            end
            tvp_pkg::S_G_SQLD:   n_state = tvp_pkg::S_G_SQRT;
            tvp_pkg::S_G_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = tvp_pkg::S_G_PEAK;
                end
            end
            tvp_pkg::S_G_PEAK:   n_state = tvp_pkg::S_G_TFIN;
            tvp_pkg::S_G_TFIN:   n_state = tvp_pkg::S_G_RES;
            tvp_pkg::S_G_CDIV: begin
                if (r_cnt == '0) begin
                    n_state = tvp_pkg::S_G_CFIN;
                end
            end
            tvp_pkg::S_G_CFIN:   n_state = tvp_pkg::S_G_RES;
            tvp_pkg::S_G_RES:    n_state = tvp_pkg::S_IDLE;
            tvp_pkg::S_U_SEL:    n_state = tvp_pkg::S_U_MUL;
            tvp_pkg::S_U_MUL:    n_state = tvp_pkg::S_U_VEL;
            tvp_pkg::S_U_VEL:    n_state = tvp_pkg::S_U_DMUL;
            tvp_pkg::S_U_DMUL:   n_state = tvp_pkg::S_U_ACC;
            tvp_pkg::S_U_ACC:    n_state = tvp_pkg::S_IDLE;
            default:             n_state = tvp_pkg::S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_req.ready          = (r_state == tvp_pkg::S_IDLE) && !r_out_valid;
        o_rsp.valid          = r_out_valid;
        o_rsp.data.setpoint  = r_out_data;
        w_load_out           = w_busy_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tvp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vel <= tvp_pkg::ONE_Q;
            r_ramp    <= tvp_pkg::ONE_Q;
            r_mode    <= tvp_pkg::MODE_DISTANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tvp_pkg::CFG_MAX_VELOCITY:  r_max_vel <= i_cfg_data;
                tvp_pkg::CFG_RAMP_TIME:     r_ramp    <= i_cfg_data;
                tvp_pkg::CFG_SETPOINT_MODE: r_mode    <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= w_result_next();
        end
    end

    function automatic logic signed [TW-1:0] w_result_next();
        logic signed [TW-1:0] v;
        v = r_result;
        if (r_state == tvp_pkg::S_G_RES) begin
            v = (r_mode == tvp_pkg::MODE_VELOCITY) ? '0 : r_meas;
        end else if (r_mode == tvp_pkg::MODE_DISTANCE) begin
            v = w_sum_sat;
        end else if (r_mode == tvp_pkg::MODE_VELOCITY) begin
            v = w_vel_signed;
        end else begin
            v = r_setpoint;
        end
        return v;
    endfunction

    // shared multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_mul_a) * PROD_W'(r_mul_b);
    end

    // profile state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint    <= '0;
            r_prev_time   <= '0;
            r_move_neg    <= 1'b0;
            r_accel       <= '0;
            r_ramp_end    <= '0;
            r_cruise_end  <= '0;
            r_profile_end <= '0;
            r_peak        <= '0;
        end else begin
            case (r_state)
                tvp_pkg::S_IDLE: begin
                    if (w_accept && i_req.data.operation == tvp_pkg::OP_GOAL) begin
                        r_move_neg <= w_dist[TW];
                    end
                end
                tvp_pkg::S_G_ACC: begin
                    if (r_den == '0) begin
                        r_accel <= '1;
                    end else if (r_cnt == '0) begin
                        r_accel <= (|w_div_num[NUM_W-1:TW]) ? '1 : w_div_num[TW-1:0];
                    end
                end
                tvp_pkg::S_G_SQRT: begin
                    if (r_cnt == '0) begin
                        r_ramp_end   <= w_sq_res;
                        r_cruise_end <= w_sq_res;
                    end
                end
                tvp_pkg::S_G_TFIN: begin
                    r_peak        <= (|w_prod_hi[VW-1:TW]) ? '1 : w_prod_hi[TW-1:0];
                    r_profile_end <= w_tr2[TW] ? '1 : w_tr2[TW-1:0];
                end
                tvp_pkg::S_G_CFIN: begin
                    r_ramp_end    <= TW'(r_ramp);
                    r_cruise_end  <= w_ce;
                    r_profile_end <= w_ce_sum[TW] ? '1 : w_ce_sum[TW-1:0];
                    r_peak        <= TW'(r_max_vel);
                end
                tvp_pkg::S_G_RES: begin
                    r_prev_time <= r_time;
                    r_setpoint  <= (r_mode == tvp_pkg::MODE_DISTANCE) ? r_meas : '0;
                end
                tvp_pkg::S_U_ACC: begin
                    r_prev_time <= r_time;
                    if (r_mode == tvp_pkg::MODE_DISTANCE) begin
                        r_setpoint <= w_sum_sat;
                    end else if (r_mode == tvp_pkg::MODE_VELOCITY) begin
                        r_setpoint <= w_vel_signed;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            tvp_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_time  <= i_req.data.time_now;
                    r_meas  <= i_req.data.measured_position;
                    r_mag   <= w_dist[TW] ? TW'(-w_dist) : w_dist[TW-1:0];
                    r_mul_a <= TW'(r_max_vel);
                    r_mul_b <= TW'(r_ramp);
                    r_num   <= NUM_W'(r_max_vel) << F;
                    r_rem   <= '0;
                    r_den   <= TW'(r_ramp);
                    r_cnt   <= CNT_W'(NUM_W - 1);
                end
            end
            tvp_pkg::S_G_ACC, tvp_pkg::S_G_TDIV, tvp_pkg::S_G_CDIV: begin
                r_num <= w_div_num;
                r_rem <= w_div_rem;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            tvp_pkg::S_G_DECIDE: begin
                r_rem <= '0;
                r_cnt <= CNT_W'(NUM_W - 1);
                if (w_tri) begin
                    r_den <= r_accel;
                    r_num <= (r_accel == '0) ? '1 : NUM_W'(r_mag) << F;
                end else begin
                    r_den <= TW'(r_max_vel);
                    r_num <= (r_max_vel == '0) ? '1 : NUM_W'(r_mag) << F;
                end
            end
            tvp_pkg::S_G_SQLD: begin
                r_sq_x   <= w_x_sat;
                r_sq_rem <= '0;
                r_sq_res <= '0;
                r_cnt    <= CNT_W'(TW - 1);
            end
            tvp_pkg::S_G_SQRT: begin
                r_sq_x   <= r_sq_x << 2;
                r_sq_rem <= w_sq_rem;
                r_sq_res <= w_sq_res;
                r_cnt    <= r_cnt - CNT_W'(1);
                r_mul_a  <= r_accel;
                r_mul_b  <= w_sq_res;
            end
            tvp_pkg::S_U_SEL: begin
                r_mul_a <= r_accel;
                if (r_time < r_ramp_end) begin
                    r_region <= tvp_pkg::RG_RAMP;
                    r_mul_b  <= r_time;
                end else if (r_time < r_cruise_end) begin
                    r_region <= tvp_pkg::RG_CRUISE;
                    r_mul_b  <= r_time - r_cruise_end;
                end else if (r_time < r_profile_end) begin
                    r_region <= tvp_pkg::RG_DOWN;
                    r_mul_b  <= r_time - r_cruise_end;
                end else begin
                    r_region <= tvp_pkg::RG_STOP;
                    r_mul_b  <= r_time - r_cruise_end;
                end
            end
            tvp_pkg::S_U_VEL: begin
                r_vm    <= w_vm;
                r_dneg  <= r_move_neg ^ w_tneg;
                r_mul_a <= TW'(w_vm);
                r_mul_b <= w_adt;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_busy_done) begin
            r_result <= w_result_next();
        end
    end

endmodule
